// ----- design/i2cee_pkg.sv -----
// Package for the serial EEPROM slave: payload structs, bus phases, register indexes.
// No dependencies.
package i2cee_pkg;

	localparam int STORE_ADDRESS_BITS_DEF = 13;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [23:0] bus_address;
		logic [15:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        dirty;
	} out_item_t;

	localparam logic [1:0] CMD_RD_BYTE = 2'd0;
	localparam logic [1:0] CMD_RD_WORD = 2'd1;
	localparam logic [1:0] CMD_WR_BYTE = 2'd2;
	localparam logic [1:0] CMD_WR_WORD = 2'd3;

	localparam logic [2:0] REG_CLK_ADR  = 3'd0;
	localparam logic [2:0] REG_DIN_ADR  = 3'd1;
	localparam logic [2:0] REG_DOUT_ADR = 3'd2;
	localparam logic [2:0] REG_BITS     = 3'd3;
	localparam logic [2:0] REG_MODE     = 3'd4;
	localparam logic [2:0] REG_SIZE     = 3'd5;
	localparam logic [2:0] REG_PAGE     = 3'd6;

	localparam logic [1:0] MODE_ADR7 = 2'd0;
	localparam logic [1:0] MODE_DEV2 = 2'd2;

	typedef enum logic [7:0] {
		PH_STANDBY   = 8'b0000_0001,
		PH_WAIT_STOP = 8'b0000_0010,
		PH_ADR7      = 8'b0000_0100,
		PH_DEVICE    = 8'b0000_1000,
		PH_ADR_HIGH  = 8'b0001_0000,
		PH_ADR_LOW   = 8'b0010_0000,
		PH_READ      = 8'b0100_0000,
		PH_WRITE     = 8'b1000_0000
	} phase_t;

	// Classified transaction handed from front to back.
	typedef struct packed {
		logic       is_rd;
		logic       rd_fixed;   // read answered with 0xFF
		logic       word_rd;
		logic       clk_set;    // write carries a new clock level
		logic       clk_val;
		logic       dat_set;
		logic       dat_val;
	} op_t;

	typedef struct packed {
		logic [23:0] clk_adr;
		logic [23:0] din_adr;
		logic [23:0] dout_adr;
		logic [8:0]  bits;
		logic [1:0]  mode;
		logic [15:0] chip_mask;
		logic [7:0]  page_mask;
	} cfg_t;

endpackage

// ----- design/i2c_serial_eeprom_slave.sv -----
// Top level of the 24Cxx-style serial EEPROM slave seen through a processor bus.
// Depends on i2cee_pkg, i2cee_front, i2cee_back (which uses i2cee_ram).
//
//  channel   direction  payload      handshake
//  in        in         in_item_t    in_valid / in_stall
//  out       out        out_item_t   out_valid / out_stall
//  apb       in/out     7 registers  psel / penable / pwrite / pready
//
// Each transaction runs through FETCH, which reads the store byte, and EXEC, which
// updates bus state and writes the byte back through the single store port.
// The front queue (two entries) keeps taking transactions while the back end works.
// After reset the back end sweeps the store to 0xFF; during the sweep transactions
// queue up but none execute; config writes work throughout.
// A read result waits in the output register; only a following read blocks on it.
module i2c_serial_eeprom_slave
	import i2cee_pkg::*;
#(
	parameter int STORE_ADDRESS_BITS = STORE_ADDRESS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cfg_t cfg_q;
	logic op_valid, op_take;
	op_t  op;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_CLK_ADR:  cfg_q.clk_adr   <= pwdata[23:0];
				REG_DIN_ADR:  cfg_q.din_adr   <= pwdata[23:0];
				REG_DOUT_ADR: cfg_q.dout_adr  <= pwdata[23:0];
				REG_BITS:     cfg_q.bits      <= pwdata[8:0];
				REG_MODE:     cfg_q.mode      <= pwdata[1:0];
				REG_SIZE:     cfg_q.chip_mask <= pwdata[15:0];
				REG_PAGE:     cfg_q.page_mask <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_CLK_ADR:  prdata = {8'd0, cfg_q.clk_adr};
			REG_DIN_ADR:  prdata = {8'd0, cfg_q.din_adr};
			REG_DOUT_ADR: prdata = {8'd0, cfg_q.dout_adr};
			REG_BITS:     prdata = {23'd0, cfg_q.bits};
			REG_MODE:     prdata = {30'd0, cfg_q.mode};
			REG_SIZE:     prdata = {16'd0, cfg_q.chip_mask};
			REG_PAGE:     prdata = {24'd0, cfg_q.page_mask};
			default:      prdata = '0;
		endcase
	end

	i2cee_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.op_valid(op_valid), .op_take(op_take), .op(op)
	);

	i2cee_back #(.STORE_ADDRESS_BITS(STORE_ADDRESS_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.op_valid(op_valid), .op_take(op_take), .op(op),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule

// ----- design/i2cee_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module i2cee_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- design/i2cee_front.sv -----
// Front end: accepts bus transactions, decodes line levels, queues classified ops.
// Depends on i2cee_pkg.
module i2cee_front
	import i2cee_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     op_valid,
	input  logic     op_take,
	output op_t      op
);
	localparam int QD = 2;

	op_t        q_q [QD];
	logic [1:0] cnt_q;
	logic       rp_q, wp_q;
	op_t        cls;
	logic       keep;
	logic [23:0] even;
	logic [2:0]  cb, db;
	logic        acc, pop;

	assign cb = cfg.bits[2:0];
	assign db = cfg.bits[5:3];
	assign even = {in_data.bus_address[23:1], 1'b0};

	always_comb begin
		cls = '0;
		keep = 1'b1;
		case (in_data.cmd)
			CMD_RD_BYTE: begin
				cls.is_rd = 1'b1;
				cls.rd_fixed = (in_data.bus_address != cfg.dout_adr);
			end
			CMD_RD_WORD: begin
				cls.is_rd = 1'b1;
				cls.word_rd = 1'b1;
			end
			CMD_WR_BYTE: begin
				cls.clk_set = (in_data.bus_address == cfg.clk_adr);
				cls.clk_val = in_data.write_data[cb];
				cls.dat_set = (in_data.bus_address == cfg.din_adr);
				cls.dat_val = in_data.write_data[db];
				keep = cls.clk_set | cls.dat_set;
			end
			default: begin
				if (even == cfg.clk_adr) begin
					cls.clk_set = 1'b1;
					cls.clk_val = in_data.write_data[{1'b1, cb}];
				end else if ({even[23:1], 1'b1} == cfg.clk_adr) begin
					cls.clk_set = 1'b1;
					cls.clk_val = in_data.write_data[{1'b0, cb}];
				end
				if (even == cfg.din_adr) begin
					cls.dat_set = 1'b1;
					cls.dat_val = in_data.write_data[{1'b1, db}];
				end else if ({even[23:1], 1'b1} == cfg.din_adr) begin
					cls.dat_set = 1'b1;
					cls.dat_val = in_data.write_data[{1'b0, db}];
				end
			end
		endcase
	end

	assign in_stall = (cnt_q == 2'(QD));
	assign acc = in_valid & ~in_stall & keep;
	assign op_valid = (cnt_q != 2'd0);
	assign op = q_q[rp_q];
	assign pop = op_valid & op_take;

	always_ff @(posedge clk) begin
		if (acc) begin
			q_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rp_q  <= 1'b0;
			wp_q  <= 1'b0;
		end else begin
			if (acc) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(acc) - 2'(pop);
		end
	end
endmodule

// ----- design/i2cee_back.sv -----
// Back end: two-wire bus state machine, byte store access, result register.
// Depends on i2cee_pkg and i2cee_ram.
module i2cee_back
	import i2cee_pkg::*;
#(
	parameter int STORE_ADDRESS_BITS = STORE_ADDRESS_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      op_valid,
	output logic      op_take,
	input  op_t       op,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);
	localparam int AW = STORE_ADDRESS_BITS;
	localparam int DEPTH = 1 << AW;

	// sequencer: FETCH reads the store byte, EXEC updates state and writes back;
	// CLR sweeps the store to 0xFF after reset
	typedef enum logic [2:0] {
		SQ_CLR   = 3'b001,
		SQ_FETCH = 3'b010,
		SQ_EXEC  = 3'b100
	} seq_t;

	seq_t        seq_q;
	logic [AW:0] clr_q;
	phase_t      ph_q;
	logic        cn_q, cb_q, dn_q, db_q, rnw_q, mod_q;
	logic [3:0]  bc_q;
	logic [18:0] dev_q;
	logic [15:0] wp_q;
	logic        ov_q;
	out_item_t   od_q;

	logic           we;
	logic [AW-1:0]  ram_a;
	logic [7:0]     ram_wd, ram_rd;
	logic [AW-1:0]  idx;

	phase_t      ph_n;
	logic [3:0]  bc_n;
	logic [18:0] dev_n;
	logic [15:0] wp_n;
	logic        rnw_n, mod_n, cn, dn, st_we;
	logic [7:0]  st_wd;
	logic [15:0] rdat;
	logic        v, rise, fall;
	logic [16:0] sz1;
	logic [3:0]  t;
	logic [4:0]  top;
	logic [2:0]  ob;

	i2cee_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(we), .addr(ram_a), .wdata(ram_wd), .rdata(ram_rd)
	);

	assign idx = dev_q[AW-1:0] | wp_q[AW-1:0];
	assign op_take = (seq_q == SQ_EXEC) & ~(op.is_rd & ov_q & out_stall);
	assign we = (seq_q == SQ_CLR) | (op_take & st_we);
	assign ram_a = (seq_q == SQ_CLR) ? clr_q[AW-1:0] : idx;
	assign ram_wd = (seq_q == SQ_CLR) ? 8'hFF : st_wd;
	assign out_valid = ov_q;
	assign out_data = od_q;
	assign sz1 = {1'b0, cfg.chip_mask} + 17'd1;
	assign ob = cfg.bits[8:6];

	always_comb begin
		ph_n = ph_q; bc_n = bc_q; dev_n = dev_q; wp_n = wp_q;
		rnw_n = rnw_q; mod_n = mod_q; st_we = 1'b0; st_wd = ram_rd;
		cn = cn_q; dn = dn_q; rdat = '0; v = dn_q;
		rise = 1'b0; fall = 1'b0; t = '0; top = '0;
		if (op.is_rd) begin
			case (ph_q)
				PH_READ: begin
					if (bc_q < 4'd9) begin
						v = ram_rd[3'(4'd8 - bc_q)];
						if (bc_q == 4'd8) begin
							wp_n = (wp_q + 16'd1) & cfg.chip_mask;
						end
					end
				end
				PH_ADR7, PH_DEVICE, PH_ADR_HIGH, PH_ADR_LOW, PH_WRITE: begin
					if (bc_q == 4'd9) begin
						v = 1'b0;
					end
				end
				default: ;
			endcase
			if (op.rd_fixed) begin
				wp_n = wp_q;
				rdat = 16'h00FF;
			end else if (!op.word_rd) begin
				rdat = {8'h00, 8'({7'd0, v} << ob)};
			end else if (cfg.dout_adr[0]) begin
				rdat = 16'({15'd0, v} << ob);
			end else begin
				rdat = 16'({15'd0, v} << ({1'b0, ob} + 4'd8));
			end
		end else begin
			cn = op.clk_set ? op.clk_val : cb_q;
			dn = op.dat_set ? op.dat_val : db_q;
			rise = ~cb_q & cn;
			fall = cb_q & ~cn;
			if (cb_q && cn) begin
				if (ph_q != PH_WAIT_STOP && db_q && !dn) begin
					bc_n = '0;
					dev_n = '0;
					if (cfg.mode == MODE_ADR7) begin
						wp_n = '0;
						ph_n = PH_ADR7;
					end else begin
						ph_n = PH_DEVICE;
					end
				end
				if (!db_q && dn) begin
					ph_n = PH_STANDBY;
				end
			end
			case (ph_q)
				PH_ADR7: begin
					if (rise && bc_n == 4'd0) begin
						bc_n = bc_n + 4'd1;
					end
					if (fall) begin
						if (bc_n < 4'd8) begin
							wp_n = wp_n | 16'({15'd0, db_q} << (4'd7 - bc_n));
						end else if (bc_n == 4'd8) begin
							rnw_n = db_q;
						end else begin
							bc_n = '0;
							wp_n = wp_n & cfg.chip_mask;
							ph_n = rnw_n ? PH_READ : PH_WRITE;
						end
						bc_n = bc_n + 4'd1;
					end
				end
				PH_DEVICE: begin
					if (rise && bc_n == 4'd0) begin
						bc_n = bc_n + 4'd1;
					end
					if (fall) begin
						if (bc_n >= 4'd5 && bc_n < 4'd8) begin
							t = 4'd15 - bc_n;
							if (cfg.mode == MODE_DEV2 ||
								{1'b0, cfg.chip_mask} < (17'd1 << t)) begin
								dev_n = dev_n | 19'({18'd0, db_q} << (4'd7 - bc_n));
							end else begin
								wp_n[t] = db_q;
							end
						end else if (bc_n == 4'd8) begin
							rnw_n = db_q;
						end else if (bc_n > 4'd8) begin
							bc_n = '0;
							if (cfg.mode == MODE_DEV2) begin
								ph_n = rnw_n ? PH_READ : PH_ADR_HIGH;
								dev_n = {dev_n[2:0], 16'd0};
							end else begin
								ph_n = rnw_n ? PH_READ : PH_ADR_LOW;
								dev_n = {dev_n[10:0], 8'd0};
							end
						end
						bc_n = bc_n + 4'd1;
					end
				end
				PH_ADR_HIGH, PH_ADR_LOW: begin
					if (fall) begin
						top = (ph_q == PH_ADR_HIGH) ? 5'd16 : 5'd8;
						if (bc_n < 4'd9) begin
							if (sz1 < (17'd1 << (top + 5'd1 - {1'b0, bc_n}))) begin
								dev_n = dev_n >> 1;
							end else begin
								wp_n[4'(top - {1'b0, bc_n})] = db_q;
							end
							bc_n = bc_n + 4'd1;
						end else begin
							bc_n = 4'd1;
							if (ph_q == PH_ADR_LOW) begin
								wp_n = wp_n & cfg.chip_mask;
								ph_n = PH_WRITE;
							end else begin
								ph_n = PH_ADR_LOW;
							end
						end
					end
				end
				PH_READ: begin
					if (fall) begin
						if (bc_n < 4'd9) begin
							bc_n = bc_n + 4'd1;
						end else begin
							bc_n = 4'd1;
							if (db_q) begin
								ph_n = PH_WAIT_STOP;
							end
						end
					end
				end
				PH_WRITE: begin
					if (fall) begin
						if (bc_n < 4'd9) begin
							// store index uses state as it was after start/stop check,
							// which leaves dev/wp untouched in this phase
							st_we = 1'b1;
							st_wd[3'(4'd8 - bc_n)] = db_q;
							mod_n = 1'b1;
							if (bc_n == 4'd8) begin
								wp_n = (wp_n & ~{8'd0, cfg.page_mask}) |
									((wp_n + 16'd1) & {8'd0, cfg.page_mask});
							end
							bc_n = bc_n + 4'd1;
						end else begin
							bc_n = 4'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_take && op.is_rd) begin
			od_q.read_data <= rdat;
			od_q.dirty <= mod_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_CLR;
			clr_q <= '0;
			ph_q <= PH_STANDBY;
			cn_q <= 1'b0; cb_q <= 1'b0; dn_q <= 1'b0; db_q <= 1'b0;
			bc_q <= '0; rnw_q <= 1'b0; dev_q <= '0; wp_q <= '0;
			mod_q <= 1'b0; ov_q <= 1'b0;
		end else begin
			// new read result loads as the old one leaves
			if (op_take && op.is_rd) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			case (seq_q)
				SQ_CLR: begin
					clr_q <= clr_q + (AW+1)'(1);
					if (clr_q == (AW+1)'(DEPTH - 1)) begin
						seq_q <= SQ_FETCH;
					end
				end
				SQ_FETCH: begin
					if (op_valid) begin
						seq_q <= SQ_EXEC;
					end
				end
				SQ_EXEC: begin
					if (op_take) begin
						seq_q <= SQ_FETCH;
						ph_q <= ph_n; bc_q <= bc_n; dev_q <= dev_n; wp_q <= wp_n;
						rnw_q <= rnw_n; mod_q <= mod_n;
						if (!op.is_rd) begin
							cn_q <= cn; dn_q <= dn; cb_q <= cn; db_q <= dn;
						end
					end
				end
				default: seq_q <= SQ_FETCH;
			endcase
		end
	end
endmodule
